/* rtl/ppg_pkg.sv */
// ---------------------------------------------------------------------------
// ppg_pkg: shared types, constants and helpers of the plasma pixel generator
// Fixed-point constants, square-root step and channel mapping.
// ---------------------------------------------------------------------------
package ppg_pkg;

   // radians to a 2^24 turn
   localparam logic [21:0] TURN_K   = 22'd2670177;
   localparam logic [21:0] TURN_K83 = 22'd2216247;
   localparam logic [21:0] TURN_K82 = 22'd2189545;

   // Q20 quarter-wave sine polynomial coefficients
   localparam logic [20:0] PC1 = 21'd1647099;
   localparam logic [19:0] PC3 = 20'd677343;
   localparam logic [16:0] PC5 = 17'd83564;
   localparam logic [12:0] PC7 = 13'd4909;

   localparam int COORD_W = 21;   // signed Q16 coordinate, sized for the smallest grid
   localparam int RAD_W   = 40;   // radius squared, Q32
   localparam int ROOT_W  = 20;   // floor root, Q16
   localparam int REM_W   = 23;

   localparam logic [1:0] SEG_RG = 2'd0;
   localparam logic [1:0] SEG_BR = 2'd1;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_state_type;

   // one digit of the restoring square root
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s);
      sqrt_state_type n;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
      trial  = {1'b0, s.root, 2'b01};
      n.rad  = {s.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         n.rem  = rem_sh - trial;
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = rem_sh;
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

   // Q15 channel to 8 bits, clamping below half a step
   function automatic logic [7:0] chan8(logic [15:0] c);
      logic [15:0] d;
      d = c - 16'd64;
      if (c < 16'd64) return 8'd0;
      return d[14:7];
   endfunction

endpackage

/* rtl/ppg_sine.sv */
// ---------------------------------------------------------------------------
// ppg_sine: pipelined Q15 sine of a 16-bit turn
// Five register stages: fold and square, three Horner steps, final scale.
// ---------------------------------------------------------------------------
module ppg_sine (
   input  logic               clock,
   input  logic [4:0]         advance,
   input  logic [15:0]        angle,
   output logic signed [15:0] sine
);
   import ppg_pkg::*;

   logic [1:0]  quad_ff [0:3];
   logic [14:0] z_ff    [0:3];
   logic [14:0] z2_ff   [0:2];
   logic [16:0] t5_ff;
   logic [19:0] t3_ff;
   logic [20:0] t1_ff;
   logic signed [15:0] sine_ff;

   logic [14:0] z_in;
   logic [29:0] zz_in;
   logic [31:0] p5_in;
   logic [36:0] p3_in;
   logic [40:0] p1_in;
   logic [35:0] ps_in;
   logic [16:0] s_in;
   logic [15:0] mag_in;

   always_comb begin
      // mirror odd quadrants
      z_in   = angle[14] ? (15'h4000 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      zz_in  = 30'(z_in) * 30'(z_in);
      p5_in  = 32'(z2_ff[0]) * 32'(PC7);
      p3_in  = 37'(z2_ff[1]) * 37'(t5_ff);
      p1_in  = 41'(z2_ff[2]) * 41'(t3_ff);
      ps_in  = 36'(z_ff[3]) * 36'(t1_ff);
      s_in   = ps_in[35:19];
      mag_in = (s_in > 17'd32767) ? 16'd32767 : s_in[15:0];
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         quad_ff[0] <= angle[15:14];
         z_ff[0]    <= z_in;
         z2_ff[0]   <= zz_in[28:14];
      end
      if (advance[1]) begin
         quad_ff[1] <= quad_ff[0];
         z_ff[1]    <= z_ff[0];
         z2_ff[1]   <= z2_ff[0];
         t5_ff      <= PC5 - p5_in[30:14];
      end
      if (advance[2]) begin
         quad_ff[2] <= quad_ff[1];
         z_ff[2]    <= z_ff[1];
         z2_ff[2]   <= z2_ff[1];
         t3_ff      <= PC3 - p3_in[33:14];
      end
      if (advance[3]) begin
         quad_ff[3] <= quad_ff[2];
         z_ff[3]    <= z_ff[2];
         t1_ff      <= PC1 - p1_in[34:14];
      end
      if (advance[4]) begin
         sine_ff <= quad_ff[3][1] ? -$signed(mag_in) : $signed(mag_in);
      end
   end

   assign sine = sine_ff;

endmodule

/* rtl/plasma_pixel_generator_unit.sv */
// ---------------------------------------------------------------------------
// plasma_pixel_generator_unit: plasma effect color for one pixel per word
// Throughput one word per cycle; each stage holds on its own when downstream
// stalls, and empty stages keep filling. The 10-stage square root (two digits
// per stage) and two ranks of 5-stage sine units set the depth.
// Synchronous reset clears the stage valid bits only.
// ---------------------------------------------------------------------------
module plasma_pixel_generator_unit #(
   parameter int GRID_SIZE = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [5:0] req_x,
   input  logic [5:0] req_y,
   input  logic [23:0] req_phase,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import ppg_pkg::*;

   localparam int NumStages = 27;

   logic [NumStages:1]   valid_ff;
   logic [NumStages:1]   valid_in;
   logic [NumStages+1:1] en;

   // coordinate table: floor(i*2^16/GRID_SIZE) - 0.5
   logic signed [COORD_W-1:0] coord_tab [0:63];
   for (genvar i = 0; i < 64; i++) begin : g_coord
      assign coord_tab[i] = COORD_W'(((i * 65536) / GRID_SIZE) - 32768);
   end

   // stage registers
   logic [15:0] ang_sa_ff, ang_cb_ff, ang_cx_ff, ang_cy_ff;
   logic [23:0] phase_ff [1:19];
   logic signed [COORD_W-1:0] p_ff [1:6];
   logic signed [COORD_W-1:0] q_ff [1:6];
   logic signed [15:0] sa, cb, cx1, cy1;
   logic signed [36:0] prod_a_ff, prod_b_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic [54:0] acc_ff;
   logic [RAD_W-1:0] sqx_ff, sqy_ff, r2_ff;
   logic [49:0] mul_lo_ff;
   logic [26:0] mul_hi_ff;
   logic [15:0] a1_ff [10:21];
   sqrt_state_type sq_ff [10:19];
   logic [24:0] sum_ff;
   logic [15:0] turn2_ff;
   logic signed [15:0] wave_a, wave_b;
   logic [7:0] red_ff, green_ff, blue_ff;

   // combinational next values
   logic [45:0] mk_in, mk82_in, mk83_in;
   logic signed [37:0] plane_in;
   logic [54:0] plane_w_in;
   logic signed [41:0] cxx_in, cyy_in;
   logic [54:0] turn1_in;
   sqrt_state_type sq_first_in;
   sqrt_state_type sq_init_in;
   logic [46:0] m2_in;
   logic signed [16:0] v_in;
   logic [16:0] w_in;
   logic [15:0] f_in, nf_in;
   logic [15:0] r_in, g_in, b_in;

   // per-stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      en[NumStages+1] = rsp_ready;
      for (int k = NumStages; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in = {valid_ff[NumStages-1:1], req_valid};
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NumStages; k++) begin
            if (en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_comb begin
      mk_in   = 46'(req_phase) * 46'(TURN_K);
      mk82_in = 46'(req_phase) * 46'(TURN_K82);
      mk83_in = 46'(req_phase) * 46'(TURN_K83);

      plane_in   = 38'(prod_a_ff) + 38'(prod_b_ff);
      plane_w_in = $unsigned(55'(plane_in));

      cxx_in = 42'(cx_ff) * 42'(cx_ff);
      cyy_in = 42'(cy_ff) * 42'(cy_ff);

      turn1_in = 55'(mul_lo_ff) + {mul_hi_ff, 28'd0};

      sq_init_in  = '{rad: r2_ff, rem: '0, root: '0};
      sq_first_in = sqrt_step(sqrt_step(sq_init_in));

      m2_in = 47'(sum_ff) * 47'(TURN_K);

      // hue wheel
      v_in  = 17'(wave_a) + 17'(wave_b);
      w_in  = {2'b00, v_in[14:0]} + {1'b0, v_in[14:0], 1'b0};
      f_in  = {1'b0, w_in[14:0]};
      nf_in = 16'h8000 - f_in;
      unique case (w_in[16:15])
         SEG_RG: begin
            r_in = f_in;  g_in = nf_in; b_in = 16'd0;
         end
         SEG_BR: begin
            b_in = f_in;  r_in = nf_in; g_in = 16'd0;
         end
         default: begin
            g_in = f_in;  b_in = nf_in; r_in = 16'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ang_sa_ff   <= mk_in[40:25];
         ang_cb_ff   <= mk82_in[39:24] + 16'h4000;
         ang_cx_ff   <= mk_in[39:24];
         ang_cy_ff   <= mk83_in[39:24];
         phase_ff[1] <= req_phase;
         p_ff[1]     <= coord_tab[req_x];
         q_ff[1]     <= coord_tab[req_y];
      end
      for (int k = 2; k <= 6; k++) begin
         if (en[k]) begin
            p_ff[k] <= p_ff[k-1];
            q_ff[k] <= q_ff[k-1];
         end
      end
      for (int k = 2; k <= 19; k++) begin
         if (en[k]) phase_ff[k] <= phase_ff[k-1];
      end
      if (en[7]) begin
         prod_a_ff <= 37'(p_ff[6]) * 37'(sa);
         prod_b_ff <= 37'(q_ff[6]) * 37'(cb);
         cx_ff     <= p_ff[6] + COORD_W'(cx1);
         cy_ff     <= q_ff[6] + COORD_W'(cy1);
      end
      if (en[8]) begin
         acc_ff <= (plane_w_in << 3) + (plane_w_in << 1) + (55'(phase_ff[7]) << 15);
         sqx_ff <= cxx_in[RAD_W-1:0];
         sqy_ff <= cyy_in[RAD_W-1:0];
      end
      if (en[9]) begin
         mul_lo_ff <= 50'(acc_ff[27:0]) * 50'(TURN_K);
         mul_hi_ff <= 27'(49'(acc_ff[54:28]) * 49'(TURN_K));
         r2_ff     <= sqx_ff + sqy_ff + (RAD_W'(1) << 31);
      end
      if (en[10]) begin
         a1_ff[10] <= turn1_in[54:39];
         sq_ff[10] <= sq_first_in;
      end
      for (int k = 11; k <= 19; k++) begin
         if (en[k]) sq_ff[k] <= sqrt_step(sqrt_step(sq_ff[k-1]));
      end
      for (int k = 11; k <= 21; k++) begin
         if (en[k]) a1_ff[k] <= a1_ff[k-1];
      end
      if (en[20]) begin
         sum_ff <= {2'b00, sq_ff[19].root, 3'b000} + {4'b0000, sq_ff[19].root, 1'b0}
                 + 25'(phase_ff[19]);
      end
      if (en[21]) begin
         turn2_ff <= m2_in[39:24];
      end
      if (en[27]) begin
         red_ff   <= chan8(r_in);
         green_ff <= chan8(g_in);
         blue_ff  <= chan8(b_in);
      end
   end

   ppg_sine u_sine_sa (.clock(clock), .advance(en[6:2]), .angle(ang_sa_ff), .sine(sa));
   ppg_sine u_sine_cb (.clock(clock), .advance(en[6:2]), .angle(ang_cb_ff), .sine(cb));
   ppg_sine u_sine_cx (.clock(clock), .advance(en[6:2]), .angle(ang_cx_ff), .sine(cx1));
   ppg_sine u_sine_cy (.clock(clock), .advance(en[6:2]), .angle(ang_cy_ff), .sine(cy1));

   ppg_sine u_wave_a (.clock(clock), .advance(en[26:22]), .angle(a1_ff[21]), .sine(wave_a));
   ppg_sine u_wave_b (.clock(clock), .advance(en[26:22]), .angle(turn2_ff), .sine(wave_b));

   assign rsp_valid = valid_ff[NumStages];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // an empty output stage never back-pressures the input
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output stage");

   // finished root leaves a remainder no larger than twice the root
   a_root_remainder: assert property (@(posedge clock) disable iff (reset)
      valid_ff[19] |-> (sq_ff[19].rem <= {2'b00, sq_ff[19].root, 1'b0}))
      else $error("square root remainder out of range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

/* tb/sv/plasma_pixel_generator_checker.sv */
// ---------------------------------------------------------------------------
// plasma_pixel_generator_checker: color predictor and scoreboard
// Watches the request and response channels, predicts the color of every
// accepted request word and compares each response word with the oldest pending prediction.
// ---------------------------------------------------------------------------
module plasma_pixel_generator_checker #(
   parameter int GRID_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [5:0]  req_x,
   input  logic [5:0]  req_y,
   input  logic [23:0] req_phase,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   output int          fail_count,
   output int          pending_count
);
   import ppg_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_color_type;

   pixel_color_type color_queue[$];

   function automatic int quarter_sine(logic [15:0] u);
      logic [1:0]  quad;
      logic [63:0] z, z2, t, s;
      quad = u[15:14];
      z    = 64'(u[13:0]);
      if (quad[0]) z = 64'h4000 - z;
      z2 = (z * z) >> 14;
      t  = 64'(PC5) - ((z2 * 64'(PC7)) >> 14);
      t  = 64'(PC3) - ((z2 * t) >> 14);
      t  = 64'(PC1) - ((z2 * t) >> 14);
      s  = (z * t) >> 19;
      if (s > 64'd32767) s = 64'd32767;
      return quad[1] ? -int'(s) : int'(s);
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res, digit;
      res   = 0;
      digit = 64'd1 << 62;
      while (digit > v) digit = digit >> 2;
      while (digit != 0) begin
         if (v >= res + digit) begin
            v   = v - (res + digit);
            res = (res >> 1) + digit;
         end else begin
            res = res >> 1;
         end
         digit = digit >> 2;
      end
      return res;
   endfunction

   function automatic logic [7:0] to_channel(logic [31:0] c);
      logic [31:0] d;
      d = (c - 32'd64) >> 7;
      if (c < 32'd64) return 8'd0;
      return d[7:0];
   endfunction

   function automatic pixel_color_type predict_color(logic [5:0] x, logic [5:0] y,
                                                     logic [23:0] ph);
      longint      p, q, sa, cb, cx, cy, plane;
      logic [63:0] ph64, acc, r2, root, a2_full;
      logic [15:0] a1, a2;
      int          v;
      logic [31:0] frac, w, f, nf, seg;
      pixel_color_type c;
      ph64 = 64'(ph);
      p  = longint'((64'(x) << 16) / GRID_SIZE) - 32768;
      q  = longint'((64'(y) << 16) / GRID_SIZE) - 32768;
      sa = quarter_sine(16'((ph64 * 64'(TURN_K)) >> 25));
      cb = quarter_sine(16'((ph64 * 64'(TURN_K82)) >> 24) + 16'h4000);
      cx = quarter_sine(16'((ph64 * 64'(TURN_K)) >> 24)) + p;
      cy = quarter_sine(16'((ph64 * 64'(TURN_K83)) >> 24)) + q;
      plane = p * sa + q * cb;
      acc = 64'(plane) * 64'd10 + (ph64 << 15);
      acc = acc * 64'(TURN_K);
      a1  = acc[54:39];
      r2  = 64'(cx * cx + cy * cy) + (64'd1 << 31);
      root = floor_root(r2);
      a2_full = (root * 64'd10 + ph64) * 64'(TURN_K);
      a2  = a2_full[39:24];
      v    = quarter_sine(a1) + quarter_sine(a2);
      frac = 32'(v) & 32'h7FFF;
      w    = frac * 3;
      seg  = w >> 15;
      f    = w & 32'h7FFF;
      nf   = 32'd32768 - f;
      if (seg == 32'(SEG_RG)) begin
         c.red = to_channel(f);  c.green = to_channel(nf); c.blue = 8'd0;
      end else if (seg == 32'(SEG_BR)) begin
         c.blue = to_channel(f); c.red = to_channel(nf);   c.green = 8'd0;
      end else begin
         c.green = to_channel(f); c.blue = to_channel(nf); c.red = 8'd0;
      end
      return c;
   endfunction

   always @(posedge clock) begin
      pixel_color_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (color_queue.size() == 0) begin
               $display("%0t: response word with nothing pending: %h %h %h",
                        $time, rsp_red, rsp_green, rsp_blue);
               fail_count = fail_count + 1;
            end else begin
               want = color_queue.pop_front();
               if (want.red !== rsp_red) begin
                  $display("%0t: red expected %0d actual %0d", $time, want.red, rsp_red);
                  fail_count = fail_count + 1;
               end
               if (want.green !== rsp_green) begin
                  $display("%0t: green expected %0d actual %0d",
                           $time, want.green, rsp_green);
                  fail_count = fail_count + 1;
               end
               if (want.blue !== rsp_blue) begin
                  $display("%0t: blue expected %0d actual %0d", $time, want.blue, rsp_blue);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            color_queue.push_back(predict_color(req_x, req_y, req_phase));
      end
      pending_count = color_queue.size();
   end

endmodule

/* tb/sv/tb_plasma_pixel_generator_unit.sv */
// ---------------------------------------------------------------------------
// tb_plasma_pixel_generator_unit: regression of the plasma pixel generator
// Directed corner pixels and phases, then random bursts of pixels with
// random response stalls, one long stall and one full drain.
// ---------------------------------------------------------------------------
module tb_plasma_pixel_generator_unit;
   localparam int RANDOM_WORDS = 500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [5:0]  req_x;
   logic [5:0]  req_y;
   logic [23:0] req_phase;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   int          fail_count;
   int          pending_count;
   int          cycle_count;
   int          sent_count;
   bit          hold_request;

   plasma_pixel_generator_unit dut (.*);

   plasma_pixel_generator_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("plasma_pixel_generator_unit regression: fail");
         $finish;
      end
   end

   // receiver: randomly chosen stall pattern; long hold on request
   initial begin
      int hold_left;
      int mode;
      bit hold_taken;
      rsp_ready  = 0;
      hold_left  = 0;
      mode       = 0;
      hold_taken = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = LONG_HOLD;
            hold_taken = 1;
         end
         if (cycle_count % 64 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_pixel(logic [5:0] x, logic [5:0] y, logic [23:0] ph);
      req_valid <= 1'b1;
      req_x     <= x;
      req_y     <= y;
      req_phase <= ph;
      do @(posedge clock); while (!req_ready);
      sent_count = sent_count + 1;
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   initial begin
      int burst;
      int wait_cycles;
      sent_count   = 0;
      reset     = 1;
      req_valid = 0;
      req_x     = 0;
      req_y     = 0;
      req_phase = 0;
      repeat (10) @(negedge clock);
      reset = 0;

      // corners and phase extremes
      send_pixel(6'd0, 6'd0, 24'd0);
      send_pixel(6'd63, 6'd63, 24'd0);
      send_pixel(6'd0, 6'd63, 24'hFFFFFF);
      send_pixel(6'd63, 6'd0, 24'hFFFFFF);
      send_pixel(6'd32, 6'd32, 24'd0);
      send_pixel(6'd32, 6'd32, 24'h800000);
      send_pixel(6'd63, 6'd63, 24'hFFFFFF);
      send_pixel(6'd0, 6'd0, 24'h000001);
      send_pixel(6'd1, 6'd62, 24'h010000);
      send_pixel(6'd62, 6'd1, 24'h7FFFFF);
      send_pixel(6'd21, 6'd42, 24'h555555);
      send_pixel(6'd42, 6'd21, 24'hAAAAAA);
      for (int k = 0; k < 8; k++)
         send_pixel(6'($urandom), 6'($urandom), 24'($urandom_range(0, 15)) << 16);

      burst = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 150) hold_request = 1;
         if (n == 350) begin
            // drain the pipeline before going on
            idle_cycles(1);
            while (pending_count != 0) @(negedge clock);
         end
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
         end
         burst = burst - 1;
         send_pixel(6'($urandom), 6'($urandom), 24'($urandom));
      end
      idle_cycles(1);

      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("sent %0d pixel words: corner pixels, phase extremes and random bursts",
               sent_count);
      $display("response stalls included a %0d-cycle hold and one full drain", LONG_HOLD);
      if (fail_count == 0 && pending_count == 0)
         $display("plasma_pixel_generator_unit regression: pass");
      else
         $display("plasma_pixel_generator_unit regression: fail");
      $finish;
   end

endmodule
